@@ hdl/rlh_pkg.sv @@
// ============================================================================
// rlh_pkg: shared types, step codes and control store for the hyperperiod unit
// Holds the item structs, the micro-operation and jump codes, and the
// read-only microprogram that steps the datapath.
// ============================================================================
package rlh_pkg;

    // Width of a period and of the running hyperperiod.
    localparam int PERIOD_WIDTH = 31;
    // Loop counter and GCD shift count both hold values up to PERIOD_WIDTH-1.
    localparam int CNT_W = $clog2(PERIOD_WIDTH);
    localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(PERIOD_WIDTH - 1);
    localparam logic [PERIOD_WIDTH-1:0] VAL_MAX = '1;

    typedef struct packed {
        logic [PERIOD_WIDTH-1:0] period;
        logic                    last_task;
    } in_item_t;

    typedef struct packed {
        logic [PERIOD_WIDTH-1:0] hyperperiod;
        logic                    overflowed;
        logic                    set_done;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_ZERO,
        OP_GINIT,
        OP_GSTEP,
        OP_DINIT,
        OP_DSTEP,
        OP_MINIT,
        OP_MSTEP,
        OP_MDONE,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_SKIP,
        C_A_NE_B,
        C_CNT_NZ,
        C_OUT_BUSY
    } cond_t;

    typedef logic [3:0] step_t;

    localparam step_t ST_WAIT  = 4'd0;
    localparam step_t ST_CHECK = 4'd1;
    localparam step_t ST_GINIT = 4'd2;
    localparam step_t ST_GSTEP = 4'd3;
    localparam step_t ST_DINIT = 4'd4;
    localparam step_t ST_DSTEP = 4'd5;
    localparam step_t ST_MINIT = 4'd6;
    localparam step_t ST_MSTEP = 4'd7;
    localparam step_t ST_MDONE = 4'd8;
    localparam step_t ST_EMIT  = 4'd9;
    localparam step_t ST_RET   = 4'd10;
    localparam step_t ST_ZERO  = 4'd11;

    // One control word: operation, jump condition, jump target, and whether
    // the operation is dropped on a cycle where the jump is taken.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  hold;
        step_t target;
    } uword_t;

    // Sequencer to datapath.
    typedef struct packed {
        op_t  op;
        logic in_ready;
    } ctrl_t;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic skip;
        logic a_ne_b;
        logic cnt_nz;
    } dp_status_t;

    // All jump qualifiers gathered for the sequencer.
    typedef struct packed {
        logic       in_valid;
        logic       out_busy;
        dp_status_t dp;
    } seq_flags_t;

    function automatic uword_t ucode_rom(step_t step);
        uword_t w;
        unique case (step)
            ST_WAIT:  w = '{op: OP_LOAD,  cond: C_NO_INPUT, hold: 1'b1, target: ST_WAIT};
            ST_CHECK: w = '{op: OP_NOP,   cond: C_SKIP,     hold: 1'b0, target: ST_ZERO};
            ST_GINIT: w = '{op: OP_GINIT, cond: C_NEVER,    hold: 1'b0, target: ST_WAIT};
            ST_GSTEP: w = '{op: OP_GSTEP, cond: C_A_NE_B,   hold: 1'b0, target: ST_GSTEP};
            ST_DINIT: w = '{op: OP_DINIT, cond: C_NEVER,    hold: 1'b0, target: ST_WAIT};
            ST_DSTEP: w = '{op: OP_DSTEP, cond: C_CNT_NZ,   hold: 1'b0, target: ST_DSTEP};
            ST_MINIT: w = '{op: OP_MINIT, cond: C_NEVER,    hold: 1'b0, target: ST_WAIT};
            ST_MSTEP: w = '{op: OP_MSTEP, cond: C_CNT_NZ,   hold: 1'b0, target: ST_MSTEP};
            ST_MDONE: w = '{op: OP_MDONE, cond: C_NEVER,    hold: 1'b0, target: ST_WAIT};
            ST_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_BUSY, hold: 1'b1, target: ST_EMIT};
            ST_RET:   w = '{op: OP_NOP,   cond: C_ALWAYS,   hold: 1'b0, target: ST_WAIT};
            ST_ZERO:  w = '{op: OP_ZERO,  cond: C_ALWAYS,   hold: 1'b0, target: ST_EMIT};
            default:  w = '{op: OP_NOP,   cond: C_ALWAYS,   hold: 1'b0, target: ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

@@ hdl/rlh_useq.sv @@
// ============================================================================
// rlh_useq: microprogram sequencer
// Step counter over the control store, with conditional jumps on the
// datapath and handshake flags.
// ============================================================================
module rlh_useq (
    input  logic               aclk,
    input  logic               aresetn,
    input  rlh_pkg::seq_flags_t flags,
    output rlh_pkg::ctrl_t     ctrl
);

    rlh_pkg::step_t  step_reg;
    rlh_pkg::step_t  step_next;
    rlh_pkg::uword_t word;
    logic            taken;

    assign word = rlh_pkg::ucode_rom(step_reg);

    always_comb begin
        unique case (word.cond)
            rlh_pkg::C_NEVER:    taken = 1'b0;
            rlh_pkg::C_ALWAYS:   taken = 1'b1;
            rlh_pkg::C_NO_INPUT: taken = !flags.in_valid;
            rlh_pkg::C_SKIP:     taken = flags.dp.skip;
            rlh_pkg::C_A_NE_B:   taken = flags.dp.a_ne_b;
            rlh_pkg::C_CNT_NZ:   taken = flags.dp.cnt_nz;
            rlh_pkg::C_OUT_BUSY: taken = flags.out_busy;
            default:             taken = 1'b0;
        endcase
    end

    always_comb begin
        step_next     = taken ? word.target : rlh_pkg::step_t'(step_reg + 4'd1);
        ctrl.op       = (taken && word.hold) ? rlh_pkg::OP_NOP : word.op;
        ctrl.in_ready = (word.op == rlh_pkg::OP_LOAD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= rlh_pkg::ST_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

@@ hdl/rlh_datapath.sv @@
// ============================================================================
// rlh_datapath: registers and operators for the LCM fold
// Binary GCD, restoring divide and shift-add multiply, each one step per
// micro-operation, plus the running hyperperiod and sticky overflow.
// ============================================================================
module rlh_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  rlh_pkg::ctrl_t                       ctrl,
    input  rlh_pkg::in_item_t                    s_item,
    output rlh_pkg::dp_status_t                  status,
    output logic [rlh_pkg::PERIOD_WIDTH-1:0]     h_value,
    output logic                                 ovf_value,
    output logic                                 last_value
);

    localparam int W = rlh_pkg::PERIOD_WIDTH;

    logic [W-1:0]               h_reg, h_next;
    logic                       ovf_reg, ovf_next;
    logic [W-1:0]               p_reg, p_next;
    logic                       last_reg, last_next;
    logic [W-1:0]               a_reg, a_next;
    logic [W-1:0]               b_reg, b_next;
    logic [rlh_pkg::CNT_W-1:0]  k_reg, k_next;
    logic [rlh_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]               q_reg, q_next;
    logic [W-1:0]               rem_reg, rem_next;
    logic [2*W-1:0]             acc_reg, acc_next;

    logic [W:0]                 trial;
    logic [W:0]                 shifted;

    assign shifted = {rem_reg, q_reg[W-1]};
    assign trial   = shifted - {1'b0, a_reg};

    always_comb begin
        h_next    = h_reg;
        ovf_next  = ovf_reg;
        p_next    = p_reg;
        last_next = last_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        k_next    = k_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        unique case (ctrl.op)
            rlh_pkg::OP_NOP: begin
            end
            rlh_pkg::OP_LOAD: begin
                p_next    = s_item.period;
                last_next = s_item.last_task;
            end
            rlh_pkg::OP_ZERO: begin
                if (!ovf_reg) begin
                    h_next = '0;
                end
            end
            rlh_pkg::OP_GINIT: begin
                a_next = h_reg;
                b_next = p_reg;
                k_next = '0;
            end
            rlh_pkg::OP_GSTEP: begin
                // Binary GCD step; hold once the two operands meet.
                if (a_reg != b_reg) begin
                    priority if (!a_reg[0] && !b_reg[0]) begin
                        a_next = a_reg >> 1;
                        b_next = b_reg >> 1;
                        k_next = k_reg + rlh_pkg::CNT_W'(1);
                    end else if (!a_reg[0]) begin
                        a_next = a_reg >> 1;
                    end else if (!b_reg[0]) begin
                        b_next = b_reg >> 1;
                    end else if (a_reg > b_reg) begin
                        a_next = (a_reg - b_reg) >> 1;
                    end else begin
                        b_next = (b_reg - a_reg) >> 1;
                    end
                end
            end
            rlh_pkg::OP_DINIT: begin
                // h / (a << k) equals (h >> k) / a, as 2^k divides h.
                q_next   = h_reg >> k_reg;
                rem_next = '0;
                cnt_next = rlh_pkg::CNT_INIT;
            end
            rlh_pkg::OP_DSTEP: begin
                if (!trial[W]) begin
                    rem_next = trial[W-1:0];
                    q_next   = {q_reg[W-2:0], 1'b1};
                end else begin
                    rem_next = shifted[W-1:0];
                    q_next   = {q_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - rlh_pkg::CNT_W'(1);
            end
            rlh_pkg::OP_MINIT: begin
                acc_next = '0;
                cnt_next = rlh_pkg::CNT_INIT;
            end
            rlh_pkg::OP_MSTEP: begin
                acc_next = {acc_reg[2*W-2:0], 1'b0}
                         + (q_reg[W-1] ? {{W{1'b0}}, p_reg} : {(2*W){1'b0}});
                q_next   = {q_reg[W-2:0], 1'b0};
                cnt_next = cnt_reg - rlh_pkg::CNT_W'(1);
            end
            rlh_pkg::OP_MDONE: begin
                if (|acc_reg[2*W-1:W]) begin
                    h_next   = rlh_pkg::VAL_MAX;
                    ovf_next = 1'b1;
                end else begin
                    h_next = acc_reg[W-1:0];
                end
            end
            rlh_pkg::OP_EMIT: begin
                if (last_reg) begin
                    h_next   = W'(1);
                    ovf_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg   <= W'(1);
            ovf_reg <= 1'b0;
        end else begin
            h_reg   <= h_next;
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg    <= p_next;
        last_reg <= last_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        k_reg    <= k_next;
        cnt_reg  <= cnt_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        acc_reg  <= acc_next;
    end

    assign status.skip   = ovf_reg || (h_reg == '0) || (p_reg == '0);
    assign status.a_ne_b = (a_reg != b_reg);
    assign status.cnt_nz = (cnt_reg != '0);

    assign h_value    = h_reg;
    assign ovf_value  = ovf_reg;
    assign last_value = last_reg;

endmodule

@@ hdl/running_lcm_hyperperiod_top.sv @@
// ============================================================================
// running_lcm_hyperperiod_top: running LCM (hyperperiod) of task periods
// Folds each period into lcm(h, p) = (h / gcd(h, p)) * p under a small
// microprogram, with saturation and a sticky overflow flag per task set.
// ============================================================================
//
//  channel | ports                        | item
//  --------+------------------------------+-------------------------------------
//  input   | s_valid, s_ready, s_item     | period, last_task
//  result  | m_valid, m_ready, m_item     | hyperperiod, overflowed, set_done
//
// One item is worked on at a time; the next is taken once the result of the
// previous one has moved into the output register.
// Each item takes a short path when the fold is trivial (zero period, zero
// hyperperiod or overflow already seen); otherwise it runs the binary GCD
// iterations, then the bit-serial divide and multiply over the period width.
// Reset (aresetn low, synchronous) sets the hyperperiod to 1, clears the
// overflow flag and empties the output register.
// A stalled result channel holds the sequencer at its emit step; the input
// stays not ready until then.
//
module running_lcm_hyperperiod_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rlh_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output rlh_pkg::out_item_t  m_item
);

    rlh_pkg::ctrl_t      ctrl;
    rlh_pkg::dp_status_t status;
    rlh_pkg::seq_flags_t flags;

    logic [rlh_pkg::PERIOD_WIDTH-1:0] h_value;
    logic                             ovf_value;
    logic                             last_value;

    logic                m_valid_reg, m_valid_next;
    rlh_pkg::out_item_t  m_item_reg, m_item_next;

    // Result slot is busy while it holds an item the sink has not taken.
    assign flags.in_valid = s_valid;
    assign flags.out_busy = m_valid_reg && !m_ready;
    assign flags.dp       = status;

    rlh_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    rlh_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .s_item     (s_item),
        .status     (status),
        .h_value    (h_value),
        .ovf_value  (ovf_value),
        .last_value (last_value)
    );

    assign s_ready = ctrl.in_ready;

    // Load the result register on the emit step; the step only fires once
    // the slot is free, so nothing is overwritten.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (ctrl.op == rlh_pkg::OP_EMIT) begin
            m_valid_next            = 1'b1;
            m_item_next.hyperperiod = h_value;
            m_item_next.overflowed  = ovf_value;
            m_item_next.set_done    = last_value;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Never emit into an occupied result slot.
    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == rlh_pkg::OP_EMIT) |-> !(m_valid_reg && !m_ready))
        else $error("result emitted while output register still held an item");

    // An overflowed result always carries the saturated value.
    a_ovf_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.overflowed) |-> (m_item.hyperperiod == rlh_pkg::VAL_MAX))
        else $error("overflow flagged without saturated hyperperiod");

    // Only one item in flight: input closes straight after an accept.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted again while an item was in work");

    // A result closing a set leaves the fold state back at its start.
    a_set_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == rlh_pkg::OP_EMIT && last_value) |=>
            (h_value == rlh_pkg::PERIOD_WIDTH'(1) && !ovf_value))
        else $error("state not restored after the last item of a set");

endmodule
